FILE: hdl/poi_pkg.sv
// Package for the planar odometry integrator core.
// Holds the sequencer state type, fixed-point constants and the CORDIC angle table.
// No dependencies.
package poi_pkg;

  // Width of the CORDIC datapath and of the cosine and sine operands (Q2.30 with headroom).
  localparam int unsigned CW = 34;
  // Width of the shared signed multiplier product.
  localparam int unsigned PW = 2 * CW;
  // Width of the scaled product that is divided by the tick rate.
  localparam int unsigned DW = 96;

  // CORDIC start value: the inverse of the rotation gain in Q2.30.
  localparam logic [CW-1:0] CordicGain = CW'(34'sd652032874);
  // Binary-angle units per radian, round(2^32 / 2pi).
  localparam logic [CW-1:0] UnitsPerRad = CW'(34'sd683565276);
  // Quarter and half turn as binary angles.
  localparam logic [31:0] QuarterTurn = 32'h4000_0000;
  localparam logic [31:0] HalfTurn    = 32'h8000_0000;

  // Fractional bits dropped after the divide: position and heading.
  localparam int unsigned ShiftPos = 14;
  localparam int unsigned ShiftHdg = 16;

  // Scaling jobs, run in this order for each velocity update.
  localparam logic [1:0] JobX = 2'd0;
  localparam logic [1:0] JobY = 2'd1;
  localparam logic [1:0] JobH = 2'd2;

  // Phases of one 64-by-32 divide digit step.
  localparam logic [1:0] DivEst = 2'd0;
  localparam logic [1:0] DivRem = 2'd1;
  localparam logic [1:0] DivFix = 2'd2;
  localparam logic [1:0] DivTop = 2'd3;

  // Arctangent of 2^-i in binary-angle units.
  localparam logic [31:0] AtanTab [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROT,
    ST_PROD,
    ST_SCL,
    ST_DIV,
    ST_ACC,
    ST_DONE
  } state_e;

endpackage

FILE: hdl/planar_odometry_integrator_core.sv
// Planar dead-reckoning odometry core: CORDIC rotation, shared multiplier and
// reciprocal divide under one sequencer.
// Depends on poi_pkg.

// A velocity transaction (tuser = 0), once accepted, runs min(CORDIC_ITERATIONS,
// 32) CORDIC rotation iterations on one shift-and-add unit, three scaling jobs
// (x, y, heading) and a move of the result into the output register; then the
// input is ready again. Each job uses the single 34 x 34 multiplier, then the
// 64 x 32 partial products with dt, then the divide by TICKS_PER_SECOND (three
// digit steps against a precomputed reciprocal, each an estimate multiply, a
// remainder multiply and corrections for an estimate one too high or one too
// low), then the accumulate. A set-pose transaction (tuser = 1) is taken in the
// idle state, loads the pose and emits nothing. The input is not ready while an
// update runs; a finished result sits in the output register, so the next input
// is taken while it waits, and an update only stalls at its end if the previous
// result is still untaken. Sine and cosine use the heading held before the
// update; positions and heading wrap, with no saturation.
module planar_odometry_integrator_core #(
  parameter int unsigned CORDIC_ITERATIONS = 24,
  parameter int unsigned TICKS_PER_SECOND  = 1000000
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // vel_x[31:0], vel_y[63:32], ang_z[95:64], time_stamp[127:96],
  // pose_x[191:128], pose_y[255:192], pose_heading[287:256]
  input  logic [287:0] s_axis_tdata_i,
  // cmd[0]
  input  logic [0:0]   s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // pos_x[63:0], pos_y[127:64], heading_out[159:128], vel_x_echo[191:160],
  // vel_y_echo[223:192], ang_z_echo[255:224], stamp_out[287:256]
  output logic [287:0] m_axis_tdata_o
);
  import poi_pkg::*;

  localparam int unsigned NIT = (CORDIC_ITERATIONS < 32) ? CORDIC_ITERATIONS : 32;
  // Divisor normalized to bit 31 and its reciprocal, floor((2^64 - 1) / d) - 2^32.
  localparam int unsigned TpsBits = $clog2(TICKS_PER_SECOND + 1);
  localparam int unsigned NrmSh   = 32 - TpsBits;
  localparam logic [31:0] DivNorm = 32'(64'(TICKS_PER_SECOND) << NrmSh);
  localparam logic [31:0] DivInv  =
    32'((64'hFFFF_FFFF_FFFF_FFFF / {32'd0, DivNorm}) - 64'h1_0000_0000);
  // Three digit steps, each through the phases DivEst, DivRem, DivFix and DivTop.
  localparam int unsigned DivCycles = 12;

  state_e state_q, state_d;

  // Pose state
  logic [63:0] x_q, y_q;
  logic [31:0] hd_q, last_q;

  // Update operands
  logic [31:0] vx_q, vy_q, wz_q, stamp_q, dt_q;

  // CORDIC registers
  logic signed [CW-1:0] cx_q, cy_q, cz_q, c_q, s_q;
  logic                 flip_q;

  logic [6:0]  cnt_q;
  logic [1:0]  job_q;
  logic [63:0] acc_q;
  logic [DW-1:0] p_q;
  logic [31:0] rem_q, qh_q, ql_q;

  logic         m_valid_q;
  logic [287:0] m_data_q;

  logic s_acc, out_load;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;
  assign out_load        = (state_q == ST_DONE) && (!m_valid_q || m_axis_tready_i);

  // CORDIC step
  logic signed [CW-1:0] dx, dy, at, nx, ny, nz;
  always_comb begin
    dx = cy_q >>> cnt_q[4:0];
    dy = cx_q >>> cnt_q[4:0];
    at = CW'(signed'({1'b0, AtanTab[cnt_q[4:0]]}));
    if (!cz_q[CW-1]) begin
      nx = cx_q - dx;
      ny = cy_q + dy;
      nz = cz_q - at;
    end else begin
      nx = cx_q + dx;
      ny = cy_q - dy;
      nz = cz_q + at;
    end
  end

  // Shared multiplier, operands chosen by phase
  logic [63:0] mag;
  logic signed [CW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] prod;
  assign mag = acc_q[63] ? (64'd0 - acc_q) : acc_q;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_PROD: begin
        case (job_q)
          JobX: begin
            mul_a = CW'(signed'(cnt_q[0] ? vy_q : vx_q));
            mul_b = cnt_q[0] ? s_q : c_q;
          end
          JobY: begin
            mul_a = CW'(signed'(cnt_q[0] ? vy_q : vx_q));
            mul_b = cnt_q[0] ? c_q : s_q;
          end
          default: begin
            mul_a = CW'(signed'(wz_q));
            mul_b = UnitsPerRad;
          end
        endcase
      end
      ST_DIV: begin
        // estimate phase: reciprocal times the high word; remainder phase: q times d
        mul_a = signed'({2'b00, (cnt_q[0] ? qh_q : DivInv)});
        mul_b = signed'({2'b00, (cnt_q[0] ? DivNorm : rem_q)});
      end
      default: begin
        mul_a = signed'({2'b00, (cnt_q[0] ? mag[63:32] : mag[31:0])});
        mul_b = signed'({2'b00, dt_q});
      end
    endcase
  end
  assign prod = mul_a * mul_b;

  // Scaled product, normalized along with the divisor
  logic [DW-1:0] psum;
  logic [127:0]  pnrm;
  assign psum = p_q + {prod[63:0], 32'd0};
  assign pnrm = {32'd0, psum} << NrmSh;

  // Quotient estimate for one digit step
  logic [63:0] qsum;
  assign qsum = prod[63:0] + {rem_q + 32'd1, p_q[DW-1:DW-32]};

  // Accumulate step
  logic [63:0] res, sres;
  always_comb begin
    res  = (job_q == JobH) ? p_q[ShiftHdg +: 64] : p_q[ShiftPos +: 64];
    sres = acc_q[63] ? (64'd0 - res) : res;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (s_acc && !s_axis_tuser_i[0]) state_d = ST_ROT;
      ST_ROT:  if (cnt_q == 7'(NIT - 1)) state_d = ST_PROD;
      ST_PROD: if (job_q == JobH || cnt_q[0]) state_d = ST_SCL;
      ST_SCL:  if (cnt_q[0]) state_d = ST_DIV;
      ST_DIV:  if (cnt_q == 7'(DivCycles - 1)) state_d = ST_ACC;
      ST_ACC:  state_d = (job_q == JobH) ? ST_DONE : ST_PROD;
      ST_DONE: if (out_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  // Control and pose state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q       <= '0;
      y_q       <= '0;
      hd_q      <= '0;
      last_q    <= '0;
      cnt_q     <= '0;
      job_q     <= JobX;
      m_valid_q <= 1'b0;
    end else begin
      if (out_load)                              m_valid_q <= 1'b1;
      else if (m_axis_tready_i)                  m_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          cnt_q <= '0;
          job_q <= JobX;
          if (s_acc) begin
            if (s_axis_tuser_i[0]) begin
              // load the pose, keep the time base
              x_q  <= s_axis_tdata_i[191:128];
              y_q  <= s_axis_tdata_i[255:192];
              hd_q <= s_axis_tdata_i[287:256];
            end else begin
              last_q <= s_axis_tdata_i[127:96];
            end
          end
        end
        ST_ROT:  cnt_q <= (cnt_q == 7'(NIT - 1)) ? 7'd0 : cnt_q + 7'd1;
        ST_PROD: cnt_q <= (job_q == JobH || cnt_q[0]) ? 7'd0 : cnt_q + 7'd1;
        ST_SCL:  cnt_q <= cnt_q[0] ? 7'd0 : cnt_q + 7'd1;
        ST_DIV:  cnt_q <= (cnt_q == 7'(DivCycles - 1)) ? 7'd0 : cnt_q + 7'd1;
        ST_ACC: begin
          cnt_q <= '0;
          case (job_q)
            JobX:    x_q  <= x_q + sres;
            JobY:    y_q  <= y_q + sres;
            default: hd_q <= hd_q + sres[31:0];
          endcase
          if (job_q != JobH) job_q <= job_q + 2'd1;
        end
        default: ;
      endcase
    end
  end

  // Datapath registers
  logic [31:0] ang_f;
  assign ang_f = hd_q - HalfTurn;
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        vx_q    <= s_axis_tdata_i[31:0];
        vy_q    <= s_axis_tdata_i[63:32];
        wz_q    <= s_axis_tdata_i[95:64];
        stamp_q <= s_axis_tdata_i[127:96];
        dt_q    <= s_axis_tdata_i[127:96] - last_q;
        // fold the heading into the right half-plane
        flip_q  <= hd_q[31] ^ (hd_q[30]);
        cx_q    <= CordicGain;
        cy_q    <= '0;
        cz_q    <= CW'(signed'((hd_q[31] ^ hd_q[30]) ? ang_f : hd_q));
      end
      ST_ROT: begin
        cx_q <= nx;
        cy_q <= ny;
        cz_q <= nz;
        c_q  <= flip_q ? -nx : nx;
        s_q  <= flip_q ? -ny : ny;
      end
      ST_PROD: begin
        if (job_q == JobH || !cnt_q[0]) acc_q <= prod[63:0];
        else if (job_q == JobX)         acc_q <= acc_q - prod[63:0];
        else                            acc_q <= acc_q + prod[63:0];
      end
      ST_SCL: begin
        if (!cnt_q[0]) begin
          p_q <= {32'd0, prod[63:0]};
        end else begin
          // top word starts the remainder, the rest is shifted out word by word
          rem_q <= pnrm[127:96];
          p_q   <= pnrm[95:0];
        end
      end
      ST_DIV: begin
        case (cnt_q[1:0])
          DivEst: begin
            qh_q <= qsum[63:32];
            ql_q <= qsum[31:0];
          end
          DivRem: rem_q <= p_q[DW-1:DW-32] - prod[31:0];
          DivFix: begin
            // estimate one too high: step back
            if (rem_q > ql_q) begin
              qh_q  <= qh_q - 32'd1;
              rem_q <= rem_q + DivNorm;
            end
          end
          default: begin
            // estimate one too low: step forward, then shift the digit in
            if (rem_q >= DivNorm) begin
              rem_q <= rem_q - DivNorm;
              p_q   <= {p_q[DW-33:0], qh_q + 32'd1};
            end else begin
              p_q   <= {p_q[DW-33:0], qh_q};
            end
          end
        endcase
      end
      default: ;
    endcase
    if (out_load) m_data_q <= {stamp_q, wz_q, vy_q, vx_q, hd_q, y_q, x_q};
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  a_rot_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROT) |-> (cnt_q < 7'(NIT)))
    else $error("CORDIC step count out of range");
  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (cnt_q < 7'(DivCycles)))
    else $error("divide step count out of range");
  a_job_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ACC) |-> (job_q != 2'd3))
    else $error("scaling job out of range");
  a_time_base: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && !s_axis_tuser_i[0]) |=>
      (state_q == ST_ROT && last_q == $past(s_axis_tdata_i[127:96])))
    else $error("velocity update did not start or lost its timestamp");
  a_done_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (m_valid_q && state_q == ST_IDLE))
    else $error("finished update did not reach the output register");

endmodule
